[src/tsc_pkg.sv]
// Shared types, constants and helpers for the triggered sample capture core.
// No dependencies; every other file in src imports this package.
package tsc_pkg;

   // Store geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Field widths
   localparam int SAMPLE_W = 8;
   localparam int COL_W    = 4;
   localparam int POS_W    = 4;
   localparam int STATE_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   // Reset value of the trigger threshold, and shift that picks the dot row
   localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 8'd128;
   localparam int DOT_SHIFT = 5;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPTURE_MODE  = 2'd1;

   // Capture modes
   localparam logic MODE_RISING     = 1'b0;
   localparam logic MODE_CONTINUOUS = 1'b1;

   // Request kinds
   localparam logic ITEM_SAMPLE = 1'b0;
   localparam logic ITEM_READ   = 1'b1;

   // Reported capture state codes
   localparam logic [STATE_W-1:0] CAP_ARMED     = 2'd0;
   localparam logic [STATE_W-1:0] CAP_CAPTURING = 2'd1;
   localparam logic [STATE_W-1:0] CAP_WAITING   = 2'd2;

   // Trigger phase, one-hot
   typedef enum logic [2:0] {
      PH_ARMED     = 3'b001,
      PH_CAPTURING = 3'b010,
      PH_WAITING   = 3'b100
   } phase_type;

   typedef struct packed {
      logic                mode;
      logic [SAMPLE_W-1:0] sample_value;
      logic [COL_W-1:0]    read_column;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0]  capture_state;
      logic [POS_W-1:0]    write_position;
      logic                frame_done;
      logic [SAMPLE_W-1:0] read_value;
      logic [SAMPLE_W-1:0] dot_pattern;
   } rsp_type;

   // Store write command from the controller
   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
      logic [SAMPLE_W-1:0] data;
   } store_wr_type;

   // Status after the step, from the controller
   typedef struct packed {
      logic [STATE_W-1:0] capture_state;
      logic [POS_W-1:0]   write_position;
      logic               frame_done;
   } ctrl_status_type;

   function automatic logic [STATE_W-1:0] phase_code(phase_type p);
      logic [STATE_W-1:0] code;
      case (p)
         PH_ARMED:     code = CAP_ARMED;
         PH_CAPTURING: code = CAP_CAPTURING;
         PH_WAITING:   code = CAP_WAITING;
         default:      code = CAP_ARMED;
      endcase
      return code;
   endfunction

endpackage

[src/triggered_sample_capture_core.sv]
// Top level of the triggered sample capture core: request/response channels,
// configuration port and result register. Uses tsc_pkg, tsc_ctrl, tsc_store.
//
// For each request, the trigger compare, store write and index update happen
// on the edge that accepts the request, and the result sits in a single
// output register on the next cycle. A new request is accepted every cycle
// as long as the result register is empty or being drained in the same
// cycle, so throughput is one request per clock.
// The sample store is cleared by reset itself; no clearing pass is needed.
// Configuration writes are always accepted and take effect on the next cycle.
module triggered_sample_capture_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tsc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tsc_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsc_pkg::CSR_DATA_W-1:0] csr_data
);
   import tsc_pkg::*;

   logic            req_fire, csr_fire;
   store_wr_type    wr;
   ctrl_status_type status;
   logic [SAMPLE_W-1:0] rd_value, rd_dot;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   // Handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;

   tsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req       (req_data),
      .csr_fire  (csr_fire),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .wr        (wr),
      .status    (status)
   );

   tsc_store u_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .read_column (req_data.read_column),
      .read_value  (rd_value),
      .dot_pattern (rd_dot)
   );

   // Result assembly; sample requests report no read data
   always_comb begin
      rsp_data_in.capture_state  = status.capture_state;
      rsp_data_in.write_position = status.write_position;
      rsp_data_in.frame_done     = status.frame_done;
      rsp_data_in.read_value     = '0;
      rsp_data_in.dot_pattern    = '0;
      if (req_data.mode == ITEM_READ) begin
         rsp_data_in.read_value  = rd_value;
         rsp_data_in.dot_pattern = rd_dot;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted request produced no result");
`endif

endmodule

[src/tsc_store.sv]
// Sample store: DEPTH entries of 8 bits, cleared at reset, one write port
// and one read port. Read path also forms the one-hot dot. Uses tsc_pkg.
module tsc_store (
   input  logic                         clock,
   input  logic                         reset,
   input  tsc_pkg::store_wr_type        wr,
   input  logic [tsc_pkg::COL_W-1:0]    read_column,
   output logic [tsc_pkg::SAMPLE_W-1:0] read_value,
   output logic [tsc_pkg::SAMPLE_W-1:0] dot_pattern
);
   import tsc_pkg::*;

   localparam int WIDE_W = IDX_W + COL_W;

   logic [SAMPLE_W-1:0] store_ff [DEPTH];
   logic [WIDE_W-1:0]   col_wide;
   logic                col_ok;

   // Write port; the array is cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   // Read port; a column past the end reads as zero
   assign col_wide = {{IDX_W{1'b0}}, read_column};
   assign col_ok   = (col_wide < WIDE_W'(DEPTH));

   always_comb begin
      read_value = '0;
      if (col_ok) begin
         read_value = store_ff[col_wide[IDX_W-1:0]];
      end
   end

   // Dot row from the top three bits
   assign dot_pattern = SAMPLE_W'(1) << (read_value >> DOT_SHIFT);

endmodule

[src/tsc_ctrl.sv]
// Capture controller: configuration registers, trigger phase and store index.
// Issues store writes and reports the state after each request. Uses tsc_pkg.
module tsc_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_fire,
   input  tsc_pkg::req_type               req,
   input  logic                           csr_fire,
   input  logic [tsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsc_pkg::CSR_DATA_W-1:0] csr_data,
   output tsc_pkg::store_wr_type          wr,
   output tsc_pkg::ctrl_status_type       status
);
   import tsc_pkg::*;

   localparam int WIDE_W = IDX_W + POS_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   logic [SAMPLE_W-1:0] level_ff;
   logic                cmode_ff;
   phase_type           phase_ff, phase_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                done;
   logic [WIDE_W-1:0]   idx_wide;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
         cmode_ff <= MODE_RISING;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_TRIGGER_LEVEL: level_ff <= csr_data[SAMPLE_W-1:0];
            CSR_CAPTURE_MODE:  cmode_ff <= csr_data[0];
            default:           ;
         endcase
      end
   end

   // Next phase and index for a sample request
   always_comb begin : p_next
      phase_type ph;
      ph       = phase_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      done     = 1'b0;
      wr.en    = 1'b0;
      wr.addr  = idx_ff;
      wr.data  = req.sample_value;
      if (req_fire && (req.mode == ITEM_SAMPLE)) begin
         if (cmode_ff == MODE_RISING) begin
            if ((ph == PH_ARMED) && (req.sample_value >= level_ff)) begin
               ph = PH_CAPTURING;
            end
            if (ph == PH_CAPTURING) begin
               wr.en = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  idx_in = '0;
                  done   = 1'b1;
                  ph     = PH_WAITING;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            // re-arm check runs in the same step that closes the frame
            if ((ph == PH_WAITING) && (req.sample_value < level_ff)) begin
               ph = PH_ARMED;
            end
            phase_in = ph;
         end else begin
            // ring capture, phase untouched
            wr.en = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               done   = 1'b1;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ARMED;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   // Status after the step
   assign idx_wide              = {{POS_W{1'b0}}, idx_in};
   assign status.capture_state  = phase_code(phase_in);
   assign status.write_position = idx_wide[POS_W-1:0];
   assign status.frame_done     = done;

`ifndef ASSERT_OFF
   a_done_wraps: assert property (@(posedge clock) disable iff (reset)
      done |-> (idx_in == '0))
      else $error("frame done without index wrap");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (wr.en && (idx_ff != LAST_IDX)) |=> (idx_ff == $past(idx_ff) + IDX_W'(1)))
      else $error("store index did not advance by one");

   a_armed_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req.mode == ITEM_SAMPLE) && (cmode_ff == MODE_RISING) &&
       (phase_ff == PH_ARMED) && (req.sample_value < level_ff))
      |=> ($stable(idx_ff) && (phase_ff == PH_ARMED)))
      else $error("armed state moved below trigger level");
`endif

endmodule
